[rtl/pft_pkg.sv]
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the 2d pose frame transform
// Payload structs, CORDIC word widths and the arctangent table.
// ----------------------------------------------------------------------------
package pft_pkg;

  // field widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned HEADING_W  = 16;
  localparam int unsigned ANGLE_BITS = 16;

  // CORDIC chain
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 32;
  localparam int unsigned TRIG_W       = 32;
  localparam int unsigned OPND_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = OPND_W + TRIG_W;
  localparam int unsigned RND_W        = PROD_W - 30;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(32'h26DD3B6A);
  localparam logic signed [XY_W-1:0] TRIG_ONE  = XY_W'(1) <<< 30;
  localparam logic signed [XY_W-1:0] TRIG_MONE = -TRIG_ONE;

  // transfer direction
  localparam logic MODE_W2L = 1'b0;
  localparam logic MODE_L2W = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_REF_X       = 2'd0;
  localparam logic [1:0] REG_REF_Y       = 2'd1;
  localparam logic [1:0] REG_REF_HEADING = 2'd2;

  // arctangent of 2^-i, 2^32 equals a full turn
  localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // input item
  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic [HEADING_W-1:0]      in_heading;
  } pft_in_t;

  // result item
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [HEADING_W-1:0]      out_heading;
    logic                      overflow;
  } pft_out_t;

  // CORDIC rotation state
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } pft_rot_t;

  // item payload carried alongside the CORDIC state
  typedef struct packed {
    logic                     mode;
    logic signed [OPND_W-1:0] u;
    logic signed [OPND_W-1:0] v;
    logic [HEADING_W-1:0]     h;
    logic [1:0]               quad;
  } pft_item_t;

endpackage

[rtl/pft_cordic_cell.sv]
// ----------------------------------------------------------------------------
// pft_cordic_cell: one rotation step of the CORDIC chain
// Performs a single micro-rotation and hands state and payload to the next cell.
// ----------------------------------------------------------------------------
module pft_cordic_cell
  import pft_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  pft_rot_t  rot_i,
  input  pft_item_t item_i,
  output logic      valid_o,
  output pft_rot_t  rot_o,
  output pft_item_t item_o
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  atan;
  pft_rot_t               rot_d;
  pft_rot_t               rot_q;
  pft_item_t              item_q;
  logic                   valid_q;

  // micro-rotation, shifts round toward minus infinity
  always_comb begin
    xs   = rot_i.x >>> STEP;
    ys   = rot_i.y >>> STEP;
    atan = signed'(ATAN_TAB[STEP]);
    if (!rot_i.z[Z_W-1]) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - atan;
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + atan;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // state and payload
  always_ff @(posedge clk_i) begin
    rot_q  <= rot_d;
    item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign item_o  = item_q;

endmodule

[rtl/pft_rotate.sv]
// ----------------------------------------------------------------------------
// pft_rotate: trig fix-up, rotation products, rounding and saturation
// Takes cos and sin from the end of the CORDIC chain and finishes the item.
// ----------------------------------------------------------------------------
module pft_rotate
  import pft_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  pft_rot_t                  rot_i,
  input  pft_item_t                 item_i,
  input  logic signed [COORD_W-1:0] ref_x_i,
  input  logic signed [COORD_W-1:0] ref_y_i,
  output logic                      valid_o,
  output pft_out_t                  out_o
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< 29;
  localparam logic signed [RND_W:0]    SAT_MAX  = (RND_W+1)'(32'sh7FFFFFFF);
  localparam logic signed [RND_W:0]    SAT_MIN  = -(RND_W+1)'(33'sh80000000);

  // stage 1: quadrant map and clamp
  logic signed [XY_W-1:0]   c_full;
  logic signed [XY_W-1:0]   s_full;
  logic signed [XY_W-1:0]   c_clmp;
  logic signed [XY_W-1:0]   s_clmp;
  logic signed [TRIG_W-1:0] c_q;
  logic signed [TRIG_W-1:0] s_q;
  pft_item_t                item1_q;
  logic                     valid1_q;

  // stage 2: products
  logic signed [PROD_W-1:0] uc_d, vs_d, vc_d, us_d;
  logic signed [PROD_W-1:0] uc_q, vs_q, vc_q, us_q;
  logic                     mode2_q;
  logic [HEADING_W-1:0]     h2_q;
  logic                     valid2_q;

  // stage 3: sums and rounding
  logic signed [PROD_W-1:0] sx;
  logic signed [PROD_W-1:0] sy;
  logic signed [PROD_W-1:0] sx_rnd;
  logic signed [PROD_W-1:0] sy_rnd;
  logic signed [RND_W-1:0]  rx_q;
  logic signed [RND_W-1:0]  ry_q;
  logic                     mode3_q;
  logic [HEADING_W-1:0]     h3_q;
  logic                     valid3_q;

  // stage 4: translation and saturation
  logic signed [RND_W:0]    fx;
  logic signed [RND_W:0]    fy;
  logic                     ovf_x;
  logic                     ovf_y;
  pft_out_t                 out_d;
  pft_out_t                 out_q;
  logic                     valid4_q;

  // quadrant of the reference heading
  always_comb begin
    case (item_i.quad)
      2'd0: begin
        c_full = rot_i.x;
        s_full = rot_i.y;
      end
      2'd1: begin
        c_full = -rot_i.y;
        s_full = rot_i.x;
      end
      2'd2: begin
        c_full = -rot_i.x;
        s_full = -rot_i.y;
      end
      default: begin
        c_full = rot_i.y;
        s_full = -rot_i.x;
      end
    endcase
    c_clmp = c_full;
    s_clmp = s_full;
    if (c_full > TRIG_ONE)  c_clmp = TRIG_ONE;
    if (c_full < TRIG_MONE) c_clmp = TRIG_MONE;
    if (s_full > TRIG_ONE)  s_clmp = TRIG_ONE;
    if (s_full < TRIG_MONE) s_clmp = TRIG_MONE;
  end

  // rotation products
  always_comb begin
    uc_d = PROD_W'(item1_q.u) * PROD_W'(c_q);
    vs_d = PROD_W'(item1_q.v) * PROD_W'(s_q);
    vc_d = PROD_W'(item1_q.v) * PROD_W'(c_q);
    us_d = PROD_W'(item1_q.u) * PROD_W'(s_q);
  end

  // sums by direction, round half up to the coordinate format
  always_comb begin
    if (mode2_q == MODE_L2W) begin
      sx = uc_q - vs_q;
      sy = us_q + vc_q;
    end else begin
      sx = uc_q + vs_q;
      sy = vc_q - us_q;
    end
    sx_rnd = sx + RND_HALF;
    sy_rnd = sy + RND_HALF;
  end

  // add reference position in local to world, then saturate
  always_comb begin
    if (mode3_q == MODE_L2W) begin
      fx = (RND_W+1)'(rx_q) + (RND_W+1)'(ref_x_i);
      fy = (RND_W+1)'(ry_q) + (RND_W+1)'(ref_y_i);
    end else begin
      fx = (RND_W+1)'(rx_q);
      fy = (RND_W+1)'(ry_q);
    end
    ovf_x = 1'b0;
    ovf_y = 1'b0;
    out_d.out_x = fx[COORD_W-1:0];
    out_d.out_y = fy[COORD_W-1:0];
    if (fx > SAT_MAX) begin
      ovf_x       = 1'b1;
      out_d.out_x = SAT_MAX[COORD_W-1:0];
    end
    if (fx < SAT_MIN) begin
      ovf_x       = 1'b1;
      out_d.out_x = SAT_MIN[COORD_W-1:0];
    end
    if (fy > SAT_MAX) begin
      ovf_y       = 1'b1;
      out_d.out_y = SAT_MAX[COORD_W-1:0];
    end
    if (fy < SAT_MIN) begin
      ovf_y       = 1'b1;
      out_d.out_y = SAT_MIN[COORD_W-1:0];
    end
    out_d.out_heading = h3_q;
    out_d.overflow    = ovf_x | ovf_y;
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    c_q     <= c_clmp[TRIG_W-1:0];
    s_q     <= s_clmp[TRIG_W-1:0];
    item1_q <= item_i;
    uc_q    <= uc_d;
    vs_q    <= vs_d;
    vc_q    <= vc_d;
    us_q    <= us_d;
    mode2_q <= item1_q.mode;
    h2_q    <= item1_q.h;
    rx_q    <= sx_rnd[PROD_W-1:30];
    ry_q    <= sy_rnd[PROD_W-1:30];
    mode3_q <= mode2_q;
    h3_q    <= h2_q;
    out_q   <= out_d;
  end

  assign valid_o = valid4_q;
  assign out_o   = out_q;

endmodule

[rtl/pose_frame_transform_2d.sv]
// ----------------------------------------------------------------------------
// pose_frame_transform_2d: 2d rigid transform between world and local frames
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   input    | start / busy       | in_i  (mode, in_x, in_y, in_heading)
//   result   | done_o strobe      | out_o (out_x, out_y, out_heading, overflow)
//   config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item is taken every cycle; busy stays low, nothing in the pipe blocks.
// The pipe has one input stage, 30 CORDIC cells (one per rotation
// step of the reference heading) and four stages of products, sums and
// saturation. The result stands on out_o for the single cycle done_o is high.
// Reset clears the reference pose to zero and empties the pipe.
// ----------------------------------------------------------------------------
module pose_frame_transform_2d
  import pft_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pft_in_t             in_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [COORD_W-1:0]  cfg_data_i,
  output logic                done_o,
  output pft_out_t            out_o
);

  logic signed [COORD_W-1:0] ref_x_q;
  logic signed [COORD_W-1:0] ref_y_q;
  logic [HEADING_W-1:0]      ref_hd_q;

  logic [Z_W-1:0]            angle;
  pft_rot_t                  rot0_d;
  pft_item_t                 item0_d;

  logic                      vld   [CORDIC_STEPS+1];
  pft_rot_t                  rot   [CORDIC_STEPS+1];
  pft_item_t                 item  [CORDIC_STEPS+1];

  // the pipe takes a transfer every cycle
  assign busy = 1'b0;

  // reference pose registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q  <= '0;
      ref_y_q  <= '0;
      ref_hd_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REF_X:       ref_x_q  <= cfg_data_i;
        REG_REF_Y:       ref_y_q  <= cfg_data_i;
        REG_REF_HEADING: ref_hd_q <= cfg_data_i[HEADING_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage: translation operands, output heading, CORDIC seed
  always_comb begin
    angle        = Z_W'(ref_hd_q) << (Z_W - ANGLE_BITS);
    rot0_d.x     = CORDIC_X0;
    rot0_d.y     = '0;
    rot0_d.z     = signed'({2'b00, angle[Z_W-3:0]});
    item0_d.mode = in_i.mode;
    item0_d.quad = angle[Z_W-1:Z_W-2];
    if (in_i.mode == MODE_L2W) begin
      item0_d.u = OPND_W'(in_i.in_x);
      item0_d.v = OPND_W'(in_i.in_y);
      item0_d.h = in_i.in_heading + ref_hd_q;
    end else begin
      item0_d.u = OPND_W'(in_i.in_x) - OPND_W'(ref_x_q);
      item0_d.v = OPND_W'(in_i.in_y) - OPND_W'(ref_y_q);
      item0_d.h = in_i.in_heading - ref_hd_q;
    end
  end

  // input transfer register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    rot[0]  <= rot0_d;
    item[0] <= item0_d;
  end

  // row of CORDIC cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    pft_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .rot_i   (rot[g]),
      .item_i  (item[g]),
      .valid_o (vld[g+1]),
      .rot_o   (rot[g+1]),
      .item_o  (item[g+1])
    );
  end

  // rotation, translation and saturation
  pft_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[CORDIC_STEPS]),
    .rot_i   (rot[CORDIC_STEPS]),
    .item_i  (item[CORDIC_STEPS]),
    .ref_x_i (ref_x_q),
    .ref_y_i (ref_y_q),
    .valid_o (done_o),
    .out_o   (out_o)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pose_frame_transform_2d
// Drives points through both transform directions under a range of reference
// poses, predicts each result with an independent CORDIC and fixed-point model
// and compares every strobed result in order against the predicted queue.
// ----------------------------------------------------------------------------
module testbench;
  import pft_pkg::*;

  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned PIPE_DEPTH      = 35;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASE_POINTS    = 200;
  localparam int unsigned POINTS_PER_POSE = 40;
  localparam int unsigned REPORT_MAX      = 10;
  localparam int unsigned ROT_STEPS       = 30;

  // index with no register behind it
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  // quadrant of the widened heading
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  pft_in_t            in_i       = '0;
  logic               cfg_we_i   = 1'b0;
  logic [1:0]         cfg_idx_i  = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;
  logic               done_o;
  pft_out_t           out_o;

  pose_frame_transform_2d dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .out_o      (out_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // arctangent of 2^-i, 2^32 per full turn
  longint arctan_step [ROT_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // reference pose as the block should hold it
  longint               pose_x;
  longint               pose_y;
  logic [HEADING_W-1:0] pose_heading;

  pft_out_t    transformed_q [$];
  int unsigned idle_pct;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned n_points;
  int unsigned n_l2w;
  int unsigned n_saturated;
  int unsigned n_poses;
  pft_out_t    want;

  function automatic longint limit_q30(input longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  // cos and sin of a heading in q2.30, first-quadrant cordic then fold
  function automatic void heading_sincos(input logic [HEADING_W-1:0] hdg,
                                         output longint cos_q30,
                                         output longint sin_q30);
    logic [31:0] turn;
    longint      x, y, z, xs, ys;
    turn = {hdg, 16'h0000};
    x = 64'sh26DD3B6A;
    y = 0;
    z = longint'({2'b00, turn[29:0]});
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_step[i];
      end
    end
    case (turn[31:30])
      QUAD_I: begin
        cos_q30 = x;
        sin_q30 = y;
      end
      QUAD_II: begin
        cos_q30 = -y;
        sin_q30 = x;
      end
      QUAD_III: begin
        cos_q30 = -x;
        sin_q30 = -y;
      end
      default: begin
        cos_q30 = y;
        sin_q30 = -x;
      end
    endcase
    cos_q30 = limit_q30(cos_q30);
    sin_q30 = limit_q30(sin_q30);
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  // top bit flags a clamp
  function automatic logic [COORD_W:0] saturate_coord(input longint v);
    if (v > COORD_HI) return {1'b1, 32'h7FFF_FFFF};
    if (v < COORD_LO) return {1'b1, 32'h8000_0000};
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  // expected result of one point under the current reference pose
  function automatic pft_out_t transform_point(input pft_in_t p);
    longint           cq, sq, px, py, dx, dy, rx, ry;
    logic [COORD_W:0] sx, sy;
    pft_out_t         r;
    heading_sincos(pose_heading, cq, sq);
    px = longint'($signed(p.in_x));
    py = longint'($signed(p.in_y));
    if (p.mode == MODE_W2L) begin
      dx = px - pose_x;
      dy = py - pose_y;
      rx = round_q30(dx * cq + dy * sq);
      ry = round_q30(dy * cq - dx * sq);
      r.out_heading = p.in_heading - pose_heading;
    end else begin
      rx = pose_x + round_q30(px * cq - py * sq);
      ry = pose_y + round_q30(px * sq + py * cq);
      r.out_heading = p.in_heading + pose_heading;
    end
    sx = saturate_coord(rx);
    sy = saturate_coord(ry);
    r.out_x    = sx[COORD_W-1:0];
    r.out_y    = sy[COORD_W-1:0];
    r.overflow = sx[COORD_W] | sy[COORD_W];
    return r;
  endfunction

  // mostly realistic magnitudes, some full range and edge values
  function automatic logic [COORD_W-1:0] any_coord();
    case ($urandom_range(5))
      0, 1, 2: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      3:       return $urandom;
      default: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_point(input logic mode, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y,
                            input logic [HEADING_W-1:0] hdg);
    pft_in_t item;
    item.mode       = mode;
    item.in_x       = x;
    item.in_y       = y;
    item.in_heading = hdg;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= item;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    transformed_q = {transformed_q, transform_point(item)};
    n_points++;
    if (mode == MODE_L2W) n_l2w++;
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk_i);
  endtask

  // write all three pose registers, only with the pipe empty
  task automatic set_pose(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [HEADING_W-1:0] hdg);
    drain_pipe();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_REF_X;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_idx_i  <= REG_REF_Y;
    cfg_data_i <= y;
    @(posedge clk_i);
    cfg_idx_i  <= REG_REF_HEADING;
    cfg_data_i <= {16'($urandom), hdg};
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    pose_x       = longint'($signed(x));
    pose_y       = longint'($signed(y));
    pose_heading = hdg;
    n_poses++;
  endtask

  // reference pose straight out of reset
  task automatic test_reset_pose();
    send_point(MODE_W2L, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_point(MODE_L2W, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_point(MODE_W2L, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
    send_point(MODE_L2W, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0001);
  endtask

  // quadrant boundaries and the diagonal of the reference heading
  task automatic test_quadrants();
    logic [HEADING_W-1:0] hdgs [7];
    hdgs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000, 16'h0001};
    foreach (hdgs[k]) begin
      set_pose(32'h0012_3456, 32'hFFF5_4321, hdgs[k]);
      send_point(k[0] ? MODE_L2W : MODE_W2L, 32'h0005_0000, 32'hFFFD_8000,
                 hdgs[k] ^ 16'h5A5A);
    end
  endtask

  // coordinates pushed past both ends of the signed range
  task automatic test_saturation();
    set_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    send_point(MODE_W2L, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_point(MODE_L2W, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF);
    send_point(MODE_W2L, 32'h7FFF_FFFF, 32'h8000_0000, 16'h1234);
    set_pose(32'h0000_0000, 32'h0000_0000, 16'h2000);
    send_point(MODE_L2W, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hE000);
    send_point(MODE_W2L, 32'h8000_0000, 32'h8000_0000, 16'h2000);
  endtask

  // a write to the unused index must leave the pose alone
  task automatic test_unused_index();
    drain_pipe();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_point(MODE_L2W, 32'h0003_0000, 32'h0004_0000, 16'h0100);
    send_point(MODE_W2L, 32'hFFFC_0000, 32'h0002_8000, 16'hF000);
  endtask

  // random points in batches, a fresh random pose per batch
  task automatic test_random_points(input int unsigned pct);
    logic [HEADING_W-1:0] hdg;
    idle_pct = pct;
    for (int unsigned k = 0; k < PHASE_POINTS; k++) begin
      if (k % POINTS_PER_POSE == 0) begin
        case ($urandom_range(3))
          0:       hdg = 16'h0000;
          1:       hdg = 16'hFFFF;
          default: hdg = 16'($urandom);
        endcase
        set_pose(any_coord(), any_coord(), hdg);
      end
      send_point($urandom_range(1) ? MODE_L2W : MODE_W2L, any_coord(), any_coord(),
                 16'($urandom));
    end
  endtask

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (out_o.overflow) n_saturated++;
      if (transformed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result with no transfer pending: x=%h y=%h hdg=%h ovf=%b",
                   out_o.out_x, out_o.out_y, out_o.out_heading, out_o.overflow);
      end else begin
        want = transformed_q.pop_front();
        if (out_o.out_x !== want.out_x || out_o.out_y !== want.out_y ||
            out_o.out_heading !== want.out_heading || out_o.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("expected x=%h y=%h hdg=%h ovf=%b, got x=%h y=%h hdg=%h ovf=%b",
                     want.out_x, want.out_y, want.out_heading, want.overflow,
                     out_o.out_x, out_o.out_y, out_o.out_heading, out_o.overflow);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pose_frame_transform_2d: mismatch");
      $finish;
    end
  end

  // test sequence
  initial begin
    idle_pct     = 34;
    pose_x       = 0;
    pose_y       = 0;
    pose_heading = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pose();
    test_quadrants();
    test_saturation();
    test_unused_index();
    test_random_points(34);
    test_random_points(61);
    test_random_points(0);

    drain_pipe();
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    if (transformed_q.size() != 0) mismatches += transformed_q.size();

    $display("%0d points transformed (%0d local to world) under %0d reference poses",
             n_points, n_l2w, n_poses);
    $display("%0d results saturated, %0d mismatches", n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("pose_frame_transform_2d: match");
    end else begin
      $display("pose_frame_transform_2d: mismatch");
    end
    $finish;
  end

endmodule
